// File: design/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

	localparam int unsigned INIT_LEN   = 12;
	localparam int unsigned STEP_W     = $clog2(INIT_LEN);
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned NIB_W      = 4;
	localparam int unsigned WAIT_W     = 8;
	localparam int unsigned AFTER_W    = 9;
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [STEP_W-1:0] LAST_INIT_STEP = STEP_W'(INIT_LEN - 1);
	localparam logic [STEP_W-1:0] LAST_BYTE_STEP = STEP_W'(1);
	localparam logic [STEP_W-1:0] FIRST_STEP     = '0;

	localparam logic [WAIT_W-1:0] STROBE_HOLD_RST  = 8'd10;
	localparam logic [WAIT_W-1:0] WRITE_SETTLE_RST = 8'd10;
	localparam logic [WAIT_W-1:0] INIT_GAP_RST     = 8'd10;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CMD  = 2'd0,
		FUNC_DATA = 2'd1,
		FUNC_INIT = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STROBE_HOLD  = 2'd0,
		REG_WRITE_SETTLE = 2'd1,
		REG_INIT_GAP     = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	// wait-after selection for each init strobe
	typedef enum logic [1:0] {
		AFTER_NONE       = 2'd0,
		AFTER_GAP        = 2'd1,
		AFTER_SETTLE_GAP = 2'd2,
		AFTER_SETTLE     = 2'd3
	} after_kind_t;

	typedef struct packed {
		logic              load;
		logic              emit;
		logic              init_mode;
		logic [STEP_W-1:0] step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// wake nibbles, nibble 2, then 0x28, 0x06, 0x01, 0x0F high nibble first
	function automatic logic [NIB_W-1:0] init_nibble(input logic [STEP_W-1:0] step);
		logic [NIB_W-1:0] nib;
		unique case (step)
			4'd0, 4'd1, 4'd2: nib = 4'h3;
			4'd3, 4'd4:       nib = 4'h2;
			4'd5:             nib = 4'h8;
			4'd6, 4'd8, 4'd10: nib = 4'h0;
			4'd7:             nib = 4'h6;
			4'd9:             nib = 4'h1;
			4'd11:            nib = 4'hF;
			default:          nib = 4'h0;
		endcase
		return nib;
	endfunction

	function automatic after_kind_t init_after(input logic [STEP_W-1:0] step);
		after_kind_t k;
		unique case (step)
			4'd0, 4'd1, 4'd2, 4'd3: k = AFTER_GAP;
			4'd5, 4'd7:             k = AFTER_SETTLE_GAP;
			4'd9, 4'd11:            k = AFTER_SETTLE;
			default:                k = AFTER_NONE;
		endcase
		return k;
	endfunction

endpackage

// File: design/lcdseq_ctrl.sv
`timescale 1ns / 1ps

module lcdseq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [lcdseq_pkg::FUNC_W-1:0] func,
	output logic                     in_ready,
	input  lcdseq_pkg::dp_status_t   status,
	output lcdseq_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BYTE = 3'b010,
		ST_INIT = 3'b100
	} state_t;

	state_t                          state_q;
	logic [lcdseq_pkg::STEP_W-1:0]   step_q;
	logic                            accept;
	logic                            emit;
	logic                            at_end;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit     = (state_q != ST_IDLE) && status.out_free;
	assign at_end   = (state_q == ST_INIT) ? (step_q == lcdseq_pkg::LAST_INIT_STEP)
	                                       : (step_q == lcdseq_pkg::LAST_BYTE_STEP);

	always_comb begin
		cmd.load      = accept;
		cmd.emit      = emit;
		cmd.init_mode = (state_q == ST_INIT);
		cmd.step      = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= lcdseq_pkg::FIRST_STEP;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= lcdseq_pkg::FIRST_STEP;
					if (accept) begin
						unique case (lcdseq_pkg::func_t'(func))
							lcdseq_pkg::FUNC_CMD,
							lcdseq_pkg::FUNC_DATA: state_q <= ST_BYTE;
							lcdseq_pkg::FUNC_INIT: state_q <= ST_INIT;
							default:               state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BYTE, ST_INIT: begin
					if (emit) begin
						if (at_end) begin
							state_q <= ST_IDLE;
							step_q  <= lcdseq_pkg::FIRST_STEP;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					step_q  <= lcdseq_pkg::FIRST_STEP;
				end
			endcase
		end
	end

endmodule

// File: design/lcdseq_dp.sv
`timescale 1ns / 1ps

module lcdseq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcdseq_pkg::WAIT_W-1:0]    cfg_data,
	input  logic [lcdseq_pkg::FUNC_W-1:0]    func,
	input  logic [lcdseq_pkg::BYTE_W-1:0]    value,
	input  lcdseq_pkg::ctrl_cmd_t            cmd,
	output lcdseq_pkg::dp_status_t           status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lcdseq_pkg::NIB_W-1:0]     nibble,
	output logic                             reg_select,
	output logic [lcdseq_pkg::WAIT_W-1:0]    wait_before,
	output logic [lcdseq_pkg::WAIT_W-1:0]    enable_hold,
	output logic [lcdseq_pkg::AFTER_W-1:0]   wait_after,
	output logic                             last
);

	logic [lcdseq_pkg::WAIT_W-1:0]  strobe_hold_q;
	logic [lcdseq_pkg::WAIT_W-1:0]  write_settle_q;
	logic [lcdseq_pkg::WAIT_W-1:0]  init_gap_q;
	logic [lcdseq_pkg::BYTE_W-1:0]  value_q;
	logic                           rs_q;
	logic                           out_valid_q;
	logic [lcdseq_pkg::NIB_W-1:0]   nibble_q;
	logic                           reg_select_q;
	logic [lcdseq_pkg::WAIT_W-1:0]  wait_before_q;
	logic [lcdseq_pkg::WAIT_W-1:0]  enable_hold_q;
	logic [lcdseq_pkg::AFTER_W-1:0] wait_after_q;
	logic                           last_q;

	logic [lcdseq_pkg::NIB_W-1:0]   nib_d;
	logic                           rs_d;
	logic [lcdseq_pkg::WAIT_W-1:0]  before_d;
	logic [lcdseq_pkg::AFTER_W-1:0] after_d;
	logic                           last_d;
	logic [lcdseq_pkg::AFTER_W-1:0] settle_gap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_hold_q  <= lcdseq_pkg::STROBE_HOLD_RST;
			write_settle_q <= lcdseq_pkg::WRITE_SETTLE_RST;
			init_gap_q     <= lcdseq_pkg::INIT_GAP_RST;
		end else if (cfg_valid) begin
			unique case (lcdseq_pkg::reg_idx_t'(cfg_index))
				lcdseq_pkg::REG_STROBE_HOLD:  strobe_hold_q  <= cfg_data;
				lcdseq_pkg::REG_WRITE_SETTLE: write_settle_q <= cfg_data;
				lcdseq_pkg::REG_INIT_GAP:     init_gap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the byte and its register-select level
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			rs_q    <= (lcdseq_pkg::func_t'(func) == lcdseq_pkg::FUNC_DATA);
		end
	end

	assign settle_gap = {1'b0, write_settle_q} + {1'b0, init_gap_q};

	always_comb begin
		if (cmd.init_mode) begin
			nib_d    = lcdseq_pkg::init_nibble(cmd.step);
			rs_d     = 1'b0;
			before_d = (cmd.step == lcdseq_pkg::FIRST_STEP) ? init_gap_q : '0;
			last_d   = (cmd.step == lcdseq_pkg::LAST_INIT_STEP);
			unique case (lcdseq_pkg::init_after(cmd.step))
				lcdseq_pkg::AFTER_GAP:        after_d = {1'b0, init_gap_q};
				lcdseq_pkg::AFTER_SETTLE_GAP: after_d = settle_gap;
				lcdseq_pkg::AFTER_SETTLE:     after_d = {1'b0, write_settle_q};
				default:                      after_d = '0;
			endcase
		end else begin
			last_d   = (cmd.step == lcdseq_pkg::LAST_BYTE_STEP);
			nib_d    = last_d ? value_q[3:0] : value_q[7:4];
			rs_d     = rs_q;
			before_d = '0;
			after_d  = last_d ? {1'b0, write_settle_q} : '0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			nibble_q      <= nib_d;
			reg_select_q  <= rs_d;
			wait_before_q <= before_d;
			enable_hold_q <= strobe_hold_q;
			wait_after_q  <= after_d;
			last_q        <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign nibble      = nibble_q;
	assign reg_select  = reg_select_q;
	assign wait_before = wait_before_q;
	assign enable_hold = enable_hold_q;
	assign wait_after  = wait_after_q;
	assign last        = last_q;

endmodule

// File: design/char_lcd_nibble_write_sequencer_unit.sv
`timescale 1ns / 1ps

// channel | handshake              | words
// --------+------------------------+------------------------------------------
// input   | in_valid / in_ready    | func[1:0], value[7:0]
// result  | out_valid / out_ready  | nibble, reg_select, wait_before,
//         |                        | enable_hold, wait_after, last
// config  | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[7:0]
//
// An input word is taken while the sequencer is idle; while the output is not stalled,
// one strobe word per cycle then enters the output register: 2 for a byte write, 12
// for init, as counted by the controller's step counter. func 3 is taken and dropped.
// A stalled output holds the current step; the next input is accepted while the final
// strobe word still waits for the receiver. Reset clears the controller and output
// valid and loads 10 into all timing registers.

module char_lcd_nibble_write_sequencer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lcdseq_pkg::FUNC_W-1:0]    func,
	input  logic [lcdseq_pkg::BYTE_W-1:0]    value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lcdseq_pkg::NIB_W-1:0]     nibble,
	output logic                             reg_select,
	output logic [lcdseq_pkg::WAIT_W-1:0]    wait_before,
	output logic [lcdseq_pkg::WAIT_W-1:0]    enable_hold,
	output logic [lcdseq_pkg::AFTER_W-1:0]   wait_after,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcdseq_pkg::WAIT_W-1:0]    cfg_data
);

	lcdseq_pkg::ctrl_cmd_t  cmd;
	lcdseq_pkg::dp_status_t status;

	// timing registers take a write in any cycle
	assign cfg_ready = 1'b1;

	lcdseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lcdseq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.value       (value),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.nibble      (nibble),
		.reg_select  (reg_select),
		.wait_before (wait_before),
		.enable_hold (enable_hold),
		.wait_after  (wait_after),
		.last        (last)
	);

	// a byte or init request keeps the input closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func != lcdseq_pkg::FUNC_NONE) |=> !in_ready)
		else $error("input open right after a byte or init request");

	// strobes are emitted only while a request is in progress
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !in_ready)
		else $error("strobe emitted while idle");

	// step never runs past the init list
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step <= lcdseq_pkg::LAST_INIT_STEP)
		else $error("step counter out of range");

	// a stalled output never lets the step advance
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !in_ready) |=> $stable(cmd.step))
		else $error("step advanced under output stall");

endmodule

// File: bench/tb_char_lcd_nibble_write_sequencer_unit.sv
`timescale 1ns / 1ps

import lcdseq_pkg::*;

typedef struct packed {
	logic [NIB_W-1:0]   nibble;
	logic               reg_select;
	logic [WAIT_W-1:0]  wait_before;
	logic [WAIT_W-1:0]  enable_hold;
	logic [AFTER_W-1:0] wait_after;
	logic               last;
} strobe_word_t;

class strobe_scoreboard;
	logic [WAIT_W-1:0] hold_units;
	logic [WAIT_W-1:0] settle_units;
	logic [WAIT_W-1:0] gap_units;
	strobe_word_t      due[$];
	int unsigned       mismatches;

	function new();
		hold_units   = STROBE_HOLD_RST;
		settle_units = WRITE_SETTLE_RST;
		gap_units    = INIT_GAP_RST;
		mismatches   = 0;
	endfunction

	function void set_reg(reg_idx_t idx, logic [WAIT_W-1:0] data);
		case (idx)
			REG_STROBE_HOLD:  hold_units   = data;
			REG_WRITE_SETTLE: settle_units = data;
			REG_INIT_GAP:     gap_units    = data;
			default: ;
		endcase
	endfunction

	function void push_strobe(logic [NIB_W-1:0] nib, logic rs, logic [WAIT_W-1:0] wait_pre,
		logic [AFTER_W-1:0] after, logic lst);
		strobe_word_t w;
		w.nibble      = nib;
		w.reg_select  = rs;
		w.wait_before = wait_pre;
		w.enable_hold = hold_units;
		w.wait_after  = after;
		w.last        = lst;
		due.push_back(w);
	endfunction

	// expected strobes of one accepted input word
	function void note_word(func_t f, logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0]  cmd;
		logic [NIB_W-1:0]   nib;
		logic [AFTER_W-1:0] after;
		case (f)
			FUNC_CMD, FUNC_DATA: begin
				push_strobe(v[7:4], f == FUNC_DATA, '0, '0, 1'b0);
				push_strobe(v[3:0], f == FUNC_DATA, '0, {1'b0, settle_units}, 1'b1);
			end
			FUNC_INIT: begin
				for (int k = 0; k < INIT_LEN; k++) begin
					case (k / 2)
						2:       cmd = 8'h28;
						3:       cmd = 8'h06;
						4:       cmd = 8'h01;
						default: cmd = 8'h0F;
					endcase
					if (k < 3)
						nib = 4'h3;
					else if (k == 3)
						nib = 4'h2;
					else
						nib = (k % 2 == 0) ? cmd[7:4] : cmd[3:0];
					if (k < 4)
						after = {1'b0, gap_units};
					else if (k == 5 || k == 7)
						after = {1'b0, settle_units} + {1'b0, gap_units};
					else if (k % 2 == 1)
						after = {1'b0, settle_units};
					else
						after = '0;
					push_strobe(nib, 1'b0, (k == 0) ? gap_units : '0, after,
						k == INIT_LEN - 1);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_word(strobe_word_t got);
		strobe_word_t want;
		if (due.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected strobe word: nib %h rs %b before %0d hold %0d after %0d last %b",
					got.nibble, got.reg_select, got.wait_before, got.enable_hold,
					got.wait_after, got.last);
			mismatches++;
			return;
		end
		want = due.pop_front();
		if (got.nibble !== want.nibble || got.reg_select !== want.reg_select ||
			got.wait_before !== want.wait_before || got.enable_hold !== want.enable_hold ||
			got.wait_after !== want.wait_after || got.last !== want.last) begin
			if (mismatches < 10) begin
				$display("strobe word mismatch at %0t", $realtime);
				$display("  expected: nib %h rs %b before %0d hold %0d after %0d last %b",
					want.nibble, want.reg_select, want.wait_before, want.enable_hold,
					want.wait_after, want.last);
				$display("  actual:   nib %h rs %b before %0d hold %0d after %0d last %b",
					got.nibble, got.reg_select, got.wait_before, got.enable_hold,
					got.wait_after, got.last);
			end
			mismatches++;
		end
	endfunction

	function int pending();
		return due.size();
	endfunction
endclass

module tb_char_lcd_nibble_write_sequencer_unit;

	// generous bound: far above the slowest legal run of this stimulus
	localparam int unsigned TIMEOUT_NS   = 400_000;
	// cycles to let a dropped func 3 word or a final strobe drain
	localparam int unsigned DRAIN_CYCLES = 3 * INIT_LEN;
	// receiver hold-off long enough to back the block up into its input
	localparam int unsigned LONG_HOLD    = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	func_t                func;
	logic [BYTE_W-1:0]    value;
	logic                 out_valid;
	logic                 out_ready;
	logic [NIB_W-1:0]     nibble;
	logic                 reg_select;
	logic [WAIT_W-1:0]    wait_before;
	logic [WAIT_W-1:0]    enable_hold;
	logic [AFTER_W-1:0]   wait_after;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	reg_idx_t             cfg_index;
	logic [WAIT_W-1:0]    cfg_data;

	strobe_scoreboard sb;
	bit               quiet;      // no idle cycles on either side while set
	bit               stall_req;  // ask the receiver for one long hold-off

	char_lcd_nibble_write_sequencer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.nibble      (nibble),
		.reg_select  (reg_select),
		.wait_before (wait_before),
		.enable_hold (enable_hold),
		.wait_after  (wait_after),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	// Draw the idle cycles in front of one word.
	function automatic int idle_len();
		return quiet ? 0 : int'($urandom_range(0, 6));
	endfunction

	// Pick a timing value, leaning on the two extremes.
	function automatic logic [WAIT_W-1:0] pick_units();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return WAIT_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one input word after a random gap; hold valid and payload until taken.
	// Valid stays high on return, so the next call either lowers it or
	// replaces the payload at the next falling edge.
	task automatic send_word(input func_t f, input logic [BYTE_W-1:0] v);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_word(f, v);
	endtask

	// Drop input valid after the last taken word.
	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Write one timing register through the config channel.
	task automatic write_reg(input reg_idx_t idx, input logic [WAIT_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every expected strobe, then let the block go idle.
	task automatic settle();
		drop_valid();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_random_config();
		write_reg(REG_STROBE_HOLD, pick_units());
		write_reg(REG_WRITE_SETTLE, pick_units());
		write_reg(REG_INIT_GAP, pick_units());
		// an unused index must leave all three registers alone
		if ($urandom_range(0, 1) == 1)
			write_reg(REG_UNUSED, WAIT_W'($urandom_range(0, 255)));
	endtask

	// Random words; func 3 is dropped by the block and does not count.
	task automatic run_phase(input int unsigned words, input bit pause_midway);
		int unsigned done;
		int unsigned pick;
		func_t       f;
		done = 0;
		while (done < words) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				f = FUNC_CMD;
			else if (pick < 80)
				f = FUNC_DATA;
			else if (pick < 92)
				f = FUNC_INIT;
			else
				f = FUNC_NONE;
			send_word(f, BYTE_W'($urandom_range(0, 255)));
			if (f != FUNC_NONE) begin
				done++;
				// hold the sender until the block has delivered everything
				if (pause_midway && done == words / 2) begin
					drop_valid();
					while (sb.pending() != 0) @(posedge clk);
				end
			end
		end
	endtask

	// Result side: random ready gaps, with one long hold-off on request.
	initial begin : result_sink
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = idle_len();
			end
			@(negedge clk);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Check every strobe word taken at a rising edge.
	always @(posedge clk) begin : result_monitor
		strobe_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.nibble      = nibble;
			got.reg_select  = reg_select;
			got.wait_before = wait_before;
			got.enable_hold = enable_hold;
			got.wait_after  = wait_after;
			got.last        = last;
			sb.check_word(got);
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FUNC_CMD;
		value     = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_STROBE_HOLD;
		cfg_data  = '0;
		quiet     = 1'b0;
		stall_req = 1'b0;
		sb        = new();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words under the reset timing
		send_word(FUNC_CMD, 8'h00);
		send_word(FUNC_CMD, 8'hFF);
		send_word(FUNC_DATA, 8'h00);
		send_word(FUNC_DATA, 8'hFF);
		send_word(FUNC_DATA, 8'hA5);
		send_word(FUNC_CMD, 8'h5A);
		send_word(FUNC_INIT, 8'h00);
		send_word(FUNC_NONE, 8'hFF);
		send_word(FUNC_INIT, 8'hFF);
		send_word(FUNC_INIT, 8'h3C);
		send_word(FUNC_NONE, 8'h00);
		send_word(FUNC_DATA, 8'h3C);
		send_word(FUNC_CMD, 8'h01);
		settle();

		// all timing at zero
		write_reg(REG_STROBE_HOLD, 8'h00);
		write_reg(REG_WRITE_SETTLE, 8'h00);
		write_reg(REG_INIT_GAP, 8'h00);
		send_word(FUNC_INIT, 8'h00);
		send_word(FUNC_CMD, 8'hF0);
		send_word(FUNC_DATA, 8'h0F);
		settle();

		// all timing at full scale: settle + gap reaches 510
		write_reg(REG_STROBE_HOLD, 8'hFF);
		write_reg(REG_WRITE_SETTLE, 8'hFF);
		write_reg(REG_INIT_GAP, 8'hFF);
		write_reg(REG_UNUSED, 8'h55);
		send_word(FUNC_INIT, 8'h55);
		send_word(FUNC_DATA, 8'hFF);
		send_word(FUNC_CMD, 8'h80);
		send_word(FUNC_NONE, 8'hAA);
		send_word(FUNC_INIT, 8'hAA);
		settle();

		// random phases, each under its own timing
		for (int p = 0; p < 6; p++) begin
			load_random_config();
			quiet = (p == 2);
			if (p == 1)
				stall_req = 1'b1;
			run_phase(40, p == 3);
			settle();
		end
		quiet = 1'b0;

		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
design/lcdseq_pkg.sv
design/lcdseq_ctrl.sv
design/lcdseq_dp.sv
design/char_lcd_nibble_write_sequencer_unit.sv
bench/tb_char_lcd_nibble_write_sequencer_unit.sv
